/* sv/hcp_pkg.sv */
// ----------------------------------------------------------------------------
// hcp_pkg: shared types and constants of the Huffman code packer
// Widths, function codes, FSM states and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package hcp_pkg;

    localparam int MAX_CODE_BITS = 30;
    localparam int TABLE_ENTRIES = 257;

    localparam int FUNC_W  = 2;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CODE_W  = 30;
    localparam int LEN_W   = 5;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int ENTRY_W = CODE_W + LEN_W;

    // Pending bits always stay below one byte.
    localparam int PEND_W  = BYTE_W - 1;
    localparam int PCNT_W  = $clog2(BYTE_W);

    // Accumulator: pending bits, one code, and the ones tail used for padding.
    localparam int ACC_W   = PEND_W + MAX_CODE_BITS + PEND_W;
    localparam int TOT_W   = $clog2(ACC_W + 1);

    localparam logic [IDX_W-1:0] EOS_INDEX = IDX_W'(256);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK_ENC,
        ST_LOOK_FLUSH,
        ST_EMIT_ENC,
        ST_EMIT_FLUSH
    } state_t;

    typedef struct packed {
        logic ram_we;      // write table entry from input item
        logic ram_re;      // start table read
        logic rd_eos;      // read end-of-string entry instead of symbol
        logic load_enc;    // build accumulator for a symbol
        logic load_flush;  // build accumulator for a flush
        logic emit;        // move one byte to the output register
        logic emit_last;   // that byte ends the item
        logic commit;      // write leftover bits back to pending
        logic clear;       // drop pending bits
    } cmd_t;

    typedef struct packed {
        logic out_free;    // output register can take a byte this cycle
        logic total_ge8;   // a whole byte sits in the accumulator
        logic total_lt16;  // at most one whole byte left
        logic pend_zero;   // nothing pending
    } status_t;

endpackage

`default_nettype wire

/* sv/hcp_ram.sv */
// ----------------------------------------------------------------------------
// hcp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/hcp_ctrl.sv */
// ----------------------------------------------------------------------------
// hcp_ctrl: item sequencer of the Huffman code packer
// Decodes each input item and steps the datapath through lookup and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_ctrl import hcp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FUNC_W-1:0] s_func,
    input  wire status_t           status,
    output cmd_t                   cmd
);

    state_t state_reg, state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        accept     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                if (accept) begin
                    case (func_t'(s_func))
                        FUNC_LOAD: begin
                            cmd.ram_we = 1'b1;
                        end
                        FUNC_ENCODE: begin
                            cmd.ram_re = 1'b1;
                            state_next = ST_LOOK_ENC;
                        end
                        FUNC_FLUSH: begin
                            // empty flush: nothing to pad, nothing to emit
                            if (!status.pend_zero) begin
                                cmd.ram_re = 1'b1;
                                cmd.rd_eos = 1'b1;
                                state_next = ST_LOOK_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK_ENC: begin
                cmd.load_enc = 1'b1;
                state_next   = ST_EMIT_ENC;
            end
            ST_LOOK_FLUSH: begin
                cmd.load_flush = 1'b1;
                state_next     = ST_EMIT_FLUSH;
            end
            ST_EMIT_ENC: begin
                if (!status.total_ge8) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = status.total_lt16;
                    if (status.total_lt16) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_FLUSH: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    cmd.clear     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/hcp_dp.sv */
// ----------------------------------------------------------------------------
// hcp_dp: datapath of the Huffman code packer
// Code table, bit accumulator, pending bits and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hcp_dp import hcp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [IDX_W-1:0]  s_entry_index,
    input  wire logic [CODE_W-1:0] s_entry_code,
    input  wire logic [LEN_W-1:0]  s_entry_length,
    input  wire logic [SYM_W-1:0]  s_symbol,
    input  wire cmd_t              cmd,
    output status_t                status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_run_last
);

    // table write: saturate length, drop code bits above it
    logic [LEN_W-1:0]   wr_len;
    logic [CODE_W-1:0]  wr_code;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [CODE_W-1:0]  rd_code;
    logic [LEN_W-1:0]   rd_len;

    always_comb begin
        wr_len = s_entry_length;
        if ({1'b0, s_entry_length} > (LEN_W + 1)'(MAX_CODE_BITS)) begin
            wr_len = LEN_W'(MAX_CODE_BITS);
        end
        wr_code = s_entry_code & ~({CODE_W{1'b1}} << wr_len);
    end

    assign wr_en   = cmd.ram_we && (s_entry_index <= EOS_INDEX);
    assign rd_addr = cmd.rd_eos ? EOS_INDEX : IDX_W'(s_symbol);

    hcp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (s_entry_index),
        .wdata ({wr_len, wr_code}),
        .re    (cmd.ram_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_code = rd_data[CODE_W-1:0];
    assign rd_len  = rd_data[ENTRY_W-1:CODE_W];

    // accumulator and pending state
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [TOT_W-1:0]  total_less8;
    logic [TOT_W-1:0]  tot_after;
    logic [ACC_W-1:0]  shifted;

    assign total_less8 = total_reg - TOT_W'(BYTE_W);
    assign tot_after   = cmd.emit ? total_less8 : total_reg;
    assign shifted     = acc_reg >> total_less8;

    always_comb begin
        acc_next   = acc_reg;
        total_next = total_reg;
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        if (cmd.load_enc) begin
            acc_next   = (ACC_W'(pend_reg) << rd_len) | ACC_W'(rd_code);
            total_next = TOT_W'(pcnt_reg) + TOT_W'(rd_len);
        end else if (cmd.load_flush) begin
            // pending bits, then end-of-string code, then ones
            acc_next   = (ACC_W'(pend_reg) << (TOT_W'(rd_len) + TOT_W'(PEND_W)))
                       | (ACC_W'(rd_code) << PEND_W)
                       | ACC_W'({PEND_W{1'b1}});
            total_next = TOT_W'(pcnt_reg) + TOT_W'(rd_len) + TOT_W'(PEND_W);
        end else if (cmd.emit) begin
            total_next = total_less8;
        end
        if (cmd.commit) begin
            pend_next = acc_reg[PEND_W-1:0] & ~({PEND_W{1'b1}} << tot_after[PCNT_W-1:0]);
            pcnt_next = tot_after[PCNT_W-1:0];
        end else if (cmd.clear) begin
            pend_next = '0;
            pcnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        total_reg <= total_next;
        if (!aresetn) begin
            pend_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            pcnt_reg <= pcnt_next;
        end
    end

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = shifted[BYTE_W-1:0];
            out_last_next  = cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = out_last_reg;

    assign status.out_free   = !out_valid_reg || m_ready;
    assign status.total_ge8  = total_reg >= TOT_W'(BYTE_W);
    assign status.total_lt16 = total_reg < TOT_W'(2 * BYTE_W);
    assign status.pend_zero  = (pcnt_reg == '0);

    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_ready))
        else $error("byte emitted over an untaken output byte");

    a_commit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (tot_after < TOT_W'(BYTE_W)))
        else $error("leftover bits do not fit the pending register");

    a_flush_has_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_flush |-> (pcnt_reg != '0))
        else $error("flush padding started with nothing pending");

    a_emit_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (total_reg >= TOT_W'(BYTE_W)))
        else $error("byte emitted from a short accumulator");

endmodule

`default_nettype wire

/* sv/huffman_code_packer_top.sv */
// ----------------------------------------------------------------------------
// huffman_code_packer_top: HPACK-style Huffman encoder
// Table load, symbol encode and end-of-string flush, up to four output bytes
// per item.
// ----------------------------------------------------------------------------
// Usage: load the 257-entry code table first (func 0, one entry per item,
// index 256 is the end-of-string code; lengths above 30 saturate, indexes
// above 256 are ignored). Encode items (func 1) append the symbol's code MSB
// first behind the pending bits and send out every completed byte, first
// code bit in bit 7, with run_last on the item's final byte; an encode that
// fills no byte sends nothing. A flush (func 2) pads a partial byte with the
// leading end-of-string bits (then ones if that code is short), sends it and
// clears the pending bits; a flush with nothing pending sends nothing.
// Sequence: one item at a time. A load or an empty flush ends on acceptance.
// An encode does the registered read of the code table, then builds the bit
// accumulator, then sends one byte per cycle through the output register,
// the last byte also writing back the leftover bits. A flush reads the
// end-of-string entry, builds the accumulator and sends one byte. Bytes
// wait in the output register while m_ready is low, stalling the sequence.
// Reading a never-loaded table entry gives undefined output.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_packer_top import hcp_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input items
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [FUNC_W-1:0] s_func,
    input  wire logic [IDX_W-1:0]  s_entry_index,
    input  wire logic [CODE_W-1:0] s_entry_code,
    input  wire logic [LEN_W-1:0]  s_entry_length,
    input  wire logic [SYM_W-1:0]  s_symbol,
    // output bytes
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_run_last
);

    cmd_t    cmd;
    status_t status;

    // sequencer: decodes the item, steps lookup / accumulate / emit
    hcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .status  (status),
        .cmd     (cmd)
    );

    // code table, accumulator, pending bits, output register
    hcp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_entry_index  (s_entry_index),
        .s_entry_code   (s_entry_code),
        .s_entry_length (s_entry_length),
        .s_symbol       (s_symbol),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_run_last     (m_run_last)
    );

endmodule

`default_nettype wire
